// ===== hdl/cfz_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Candle flicker zone package
// Shared constants, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cfz_pkg;

  localparam int unsigned MaxZones      = 16;
  localparam int unsigned MaxLedsPerZone = 64;
  localparam int unsigned MaxPixels     = 1024;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_BASE   = 3'd0,
    REG_MIN    = 3'd1,
    REG_MAX    = 3'd2,
    REG_STRENGTH = 3'd3,
    REG_RECOVERY = 3'd4,
    REG_DIP    = 3'd5,
    REG_LIGHTS = 3'd6,
    REG_HUESAT = 3'd7
  } reg_idx_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_LOAD    = 4'd1,  // capture beat, advance time on frame start
    OP_TIMEX   = 4'd2,  // acc * 1000, low half
    OP_TIMEX2  = 4'd3,  // acc * 1000, high half combine
    OP_HASH_W  = 4'd4,  // w = v ^ (v >> 13) for current hash operand
    OP_HASH_SQ = 4'd5,  // w * w
    OP_HASH_IN = 4'd6,  // * 60493 + 19990303
    OP_HASH_OUT = 4'd7, // w * inner + c, accumulate
    OP_TGT_A   = 4'd8,  // strength * (max - min)
    OP_TGT_B   = 4'd9,  // * (noise - 32768)
    OP_DIP     = 4'd10, // finish target; level * severity on a dip
    OP_REC_A   = 4'd11, // (target - level) * recovery
    OP_REC_B   = 4'd12, // add, clamp
    OP_VAL     = 4'd13  // write back, level * 255 / 25600
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] hsel;   // hash operand: 0 tx, 1 zone*100, 2 acc>>16, 3 zone
    logic       hclr;   // clear the hash sum before accumulating
  } dp_cmd_t;

  typedef struct packed {
    logic zone_ok;
    logic dip;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/candle_flicker_zone_generator_unit.sv =====
// Input stalls from an accepted beat until its zone is done and its pixels are sent.
// One zone is worked at a time; a 24-step operation sequence sets the pace.
// Reset is asynchronous, active low; levels read as 12800 until first written.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Candle flicker zone generator
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
module candle_flicker_zone_generator_unit import cfz_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        frame_start_i,
  input  wire logic [23:0] time_step_i,
  input  wire logic [3:0]  zone_number_i,
  input  wire logic [15:0] dip_draw_i,
  input  wire logic [10:0] pixel_limit_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [9:0]       led_index_o,
  output logic [7:0]       hue_o,
  output logic [7:0]       saturation_o,
  output logic [7:0]       value_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [14:0] base_q, min_q, max_q;
  logic [15:0] str_q, rec_q, dip_q, hs_q;
  logic [6:0]  lights_q;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 15'd12800; min_q <= 15'd0; max_q <= 15'd25600;
      str_q <= 16'd4096; rec_q <= 16'd6554; dip_q <= 16'd0;
      lights_q <= 7'd1; hs_q <= 16'd0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_BASE:     base_q <= cfg_data_i[14:0];
        REG_MIN:      min_q <= cfg_data_i[14:0];
        REG_MAX:      max_q <= cfg_data_i[14:0];
        REG_STRENGTH: str_q <= cfg_data_i;
        REG_RECOVERY: rec_q <= cfg_data_i;
        REG_DIP:      dip_q <= cfg_data_i;
        REG_LIGHTS:   lights_q <= cfg_data_i[6:0];
        REG_HUESAT:   hs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cfz_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .zone_number_i, .pixel_limit_i,
    .lights_i(lights_q), .sts_i(sts), .cmd_o(cmd), .out_valid_o, .out_stall_i,
    .led_index_o, .last_o
  );

  cfz_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .frame_start_i, .time_step_i,
    .zone_number_i, .dip_draw_i, .base_i(base_q), .min_i(min_q), .max_i(max_q),
    .strength_i(str_q), .recovery_i(rec_q), .dip_chance_i(dip_q), .value_o
  );

  assign hue_o = hs_q[15:8];
  assign saturation_o = hs_q[7:0];

endmodule
`default_nettype wire

// ===== hdl/cfz_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Candle flicker zone datapath
// Time accumulator, zone levels, shared product register and the per-zone math.
// ----------------------------------------------------------------------------
module cfz_datapath import cfz_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_sts_t          sts_o,
  input  wire logic        frame_start_i,
  input  wire logic [23:0] time_step_i,
  input  wire logic [3:0]  zone_number_i,
  input  wire logic [15:0] dip_draw_i,
  input  wire logic [14:0] base_i,
  input  wire logic [14:0] min_i,
  input  wire logic [14:0] max_i,
  input  wire logic [15:0] strength_i,
  input  wire logic [15:0] recovery_i,
  input  wire logic [15:0] dip_chance_i,
  output logic [7:0]       value_o
);

  logic [39:0] acc_q, acc_d;
  logic [15:0] lvl_q [MaxZones];
  logic [MaxZones-1:0] lvl_vld_q;
  logic [3:0]  zone_q;
  logic        zok_q, dip_q;
  logic [31:0] tx_q, w_q, sq_q, hsum_q;
  logic [31:0] m_lo_q;          // partial product of the time scaling
  logic signed [47:0] prod_q;   // shared signed product register
  logic signed [17:0] level_q;
  logic signed [19:0] target_q;
  logic [15:0] noise;
  logic [31:0] hop, hraw;
  logic signed [47:0] rec_sum;
  logic signed [20:0] lv_new;
  logic [20:0] val_n;
  logic [22:0] val_m;
  logic [7:0]  value_q;

  assign noise = 16'(hsum_q[30:15]);

  // Hash operand selection.
  always_comb begin
    case (cmd_i.hsel)
      2'd0:    hop = tx_q;
      2'd1:    hop = 32'(zone_q) * 32'd100;
      2'd2:    hop = 32'(acc_q[39:16]);
      default: hop = 32'(zone_q);
    endcase
  end

  assign hraw = w_q * (sq_q) + 32'd1376312589;

  // Recovery sum, shifted with rounding toward zero.
  always_comb begin
    if (prod_q < 0) rec_sum = -((-prod_q) >>> 16);
    else rec_sum = prod_q >>> 16;
    lv_new = 21'(level_q) + 21'(rec_sum);
  end

  // Pixel value: level * 51 / 5120, the division done as a shift by 10 and a
  // reciprocal multiplication by 3277 / 2^14.
  assign val_n = 21'(level_q[14:0]) * 21'd51;
  assign val_m = 23'(val_n[20:10]) * 23'd3277;

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.op == OP_LOAD && frame_start_i) acc_d = acc_q + 40'(time_step_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      lvl_vld_q <= '0;
    end else begin
      acc_q <= acc_d;
      if (cmd_i.op == OP_REC_B && zok_q) begin
        lvl_vld_q[zone_q] <= 1'b1;
      end
    end
  end

  // Datapath registers, one operation per cycle.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        zone_q <= zone_number_i;
        zok_q  <= 32'(zone_number_i) < MaxZones;
        dip_q  <= dip_draw_i < dip_chance_i;
      end
      OP_TIMEX: m_lo_q <= 32'(acc_q[15:0]) * 32'd1000;
      OP_TIMEX2: tx_q <= 32'({8'd0, acc_q[39:16]}) * 32'd1000 + 32'(m_lo_q[31:16]);
      OP_HASH_W: begin
        w_q <= hop ^ (hop >> 13);
        if (cmd_i.hclr) hsum_q <= '0;
      end
      OP_HASH_SQ: sq_q <= w_q * w_q;
      OP_HASH_IN: sq_q <= sq_q * 32'd60493 + 32'd19990303;
      OP_HASH_OUT: hsum_q <= (hsum_q + (hraw & 32'h7fffffff)) & 32'h7fffffff;
      OP_TGT_A: prod_q <= 48'(signed'({1'b0, strength_i}))
                        * 48'(signed'({1'b0, max_i}) - signed'({1'b0, min_i}));
      OP_TGT_B: begin
        prod_q <= 48'(signed'(prod_q[33:0])) * 48'(signed'({1'b0, noise}) - 48'sd32768);
        level_q <= lvl_vld_q[zone_q] ? 18'(lvl_q[zone_q]) : 18'd12800;
      end
      OP_DIP: begin
        // prod_q holds strength*diff*(noise-32768); finish target first
        target_q <= 20'(signed'({1'b0, base_i})) + 20'((prod_q < 0) ?
                    -((-prod_q) >>> 28) : (prod_q >>> 28));
        if (dip_q)
          level_q <= 18'((48'(level_q) * 48'(19661 + (noise >> 1))) >>> 16);
      end
      OP_REC_A: prod_q <= 48'(target_q - level_q) * 48'(signed'({1'b0, recovery_i}));
      OP_REC_B: begin
        // Upper clamp first; with crossed clamps the lower one wins.
        if (lv_new > 21'(signed'({1'b0, max_i})))
          level_q <= (max_i < min_i) ? 18'(min_i) : 18'(max_i);
        else if (lv_new < 21'(signed'({1'b0, min_i}))) level_q <= 18'(min_i);
        else level_q <= 18'(lv_new);
      end
      OP_VAL: begin
        if (zok_q) lvl_q[zone_q] <= 16'(level_q);
        if (val_m[22:14] > 9'd255) value_q <= 8'd255;
        else value_q <= val_m[21:14];
      end
      default: ;
    endcase
  end

  assign value_o = value_q;
  assign sts_o.zone_ok = zok_q;
  assign sts_o.dip = dip_q;

endmodule
`default_nettype wire

// ===== hdl/cfz_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Candle flicker zone controller
// Sequences the datapath operations and emits one pixel beat per LED below the limit.
// ----------------------------------------------------------------------------
module cfz_ctrl import cfz_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  zone_number_i,
  input  wire logic [10:0] pixel_limit_i,
  input  wire logic [6:0]  lights_i,
  input  wire dp_sts_t     sts_i,
  output dp_cmd_t          cmd_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [9:0]       led_index_o,
  output logic             last_o
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_EMIT} state_e;

  state_e      state_q;
  logic [4:0]  pc_q;
  logic [3:0]  zone_q;
  logic [6:0]  i_q, leds_q, cnt_q;
  logic [10:0] base_q, limit_q;
  logic [10:0] idx;

  assign in_stall_o = (state_q != S_IDLE);
  assign idx = base_q + 11'(i_q);

  // Microcode: time, hash x and y (4 ops each), target, dip hashes, dip, recovery, value.
  always_comb begin
    cmd_o = '{op: OP_NONE, hsel: 2'd0, hclr: 1'b0};
    if (state_q == S_RUN) begin
      case (pc_q)
        5'd0:  cmd_o.op = OP_TIMEX;
        5'd1:  cmd_o.op = OP_TIMEX2;
        5'd2:  cmd_o = '{op: OP_HASH_W, hsel: 2'd0, hclr: 1'b1};
        5'd3:  cmd_o.op = OP_HASH_SQ;
        5'd4:  cmd_o.op = OP_HASH_IN;
        5'd5:  cmd_o.op = OP_HASH_OUT;
        5'd6:  cmd_o = '{op: OP_HASH_W, hsel: 2'd1, hclr: 1'b0};
        5'd7:  cmd_o.op = OP_HASH_SQ;
        5'd8:  cmd_o.op = OP_HASH_IN;
        5'd9:  cmd_o.op = OP_HASH_OUT;
        5'd10: cmd_o.op = OP_TGT_A;
        5'd11: cmd_o.op = OP_TGT_B;
        5'd12: cmd_o = '{op: OP_HASH_W, hsel: 2'd2, hclr: 1'b1};
        5'd13: cmd_o.op = OP_HASH_SQ;
        5'd14: cmd_o.op = OP_HASH_IN;
        5'd15: cmd_o.op = OP_HASH_OUT;
        5'd16: cmd_o = '{op: OP_HASH_W, hsel: 2'd3, hclr: 1'b0};
        5'd17: cmd_o.op = OP_HASH_SQ;
        5'd18: cmd_o.op = OP_HASH_IN;
        5'd19: cmd_o.op = OP_HASH_OUT;
        5'd20: cmd_o.op = OP_DIP;
        5'd21: cmd_o.op = OP_REC_A;
        5'd22: cmd_o.op = OP_REC_B;
        5'd23: cmd_o.op = OP_VAL;
        default: cmd_o.op = OP_NONE;
      endcase
    end else if (state_q == S_IDLE && in_valid_i) begin
      cmd_o.op = OP_LOAD;
    end
  end

  // State machine; count of pixels to emit: min(leds, limit - base), floored at zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q <= '0;
      i_q <= '0;
      zone_q <= '0;
      leds_q <= '0;
      cnt_q <= '0;
      base_q <= '0;
      limit_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          state_q <= S_RUN;
          pc_q <= '0;
          zone_q <= zone_number_i;
          leds_q <= (lights_i > 7'(MaxLedsPerZone)) ? 7'(MaxLedsPerZone) : lights_i;
          limit_q <= (pixel_limit_i > 11'(MaxPixels)) ? 11'(MaxPixels) : pixel_limit_i;
        end
        S_RUN: begin
          if (pc_q == 5'd0) base_q <= 11'(zone_q) * 11'(leds_q);
          if (pc_q == 5'd1)
            cnt_q <= (base_q >= limit_q) ? 7'd0 :
                     ((limit_q - base_q) < 11'(leds_q)) ? 7'(limit_q - base_q) : leds_q;
          pc_q <= pc_q + 5'd1;
          if (pc_q == 5'd23) begin
            if (sts_i.zone_ok && cnt_q != 7'd0) begin
              state_q <= S_EMIT;
              i_q <= '0;
              out_valid_o <= 1'b1;
            end else state_q <= S_IDLE;
          end
        end
        S_EMIT: if (!out_stall_i) begin
          if (i_q + 7'd1 == cnt_q) begin
            out_valid_o <= 1'b0;
            state_q <= S_IDLE;
          end else i_q <= i_q + 7'd1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign led_index_o = idx[9:0];
  assign last_o = (i_q + 7'd1 == cnt_q);

endmodule
`default_nettype wire

// ===== hdl/cfz_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Candle flicker zone checker
// Port-level properties of the generator, attached by bind.
// ----------------------------------------------------------------------------
module cfz_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [9:0] led_index_o,
  input wire logic       last_o
);

  // No input is taken while pixels are still being sent.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during emit");

  // A pixel beat that is not last is followed by another pixel beat.
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o)
    else $error("pixel burst broken");

  // Pixel indexes increase by one within a burst.
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> led_index_o == $past(led_index_o) + 10'd1)
    else $error("pixel index skipped");

  // A stalled pixel holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(led_index_o))
    else $error("stalled pixel changed");

endmodule

bind candle_flicker_zone_generator_unit cfz_checker u_cfz_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .led_index_o, .last_o
);
`default_nettype wire
